// File: src/point_in_polygon_test_macros.svh
// Assertion macros for the point-in-polygon test block.
// Used by point_in_polygon_test.sv; expects clk and rst_n in scope.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PIP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pip_pkg.sv
// Package for the point-in-polygon test block: field widths, codes, defaults.
// No dependencies.
package pip_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_COORD_WIDTH  = 16;

  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int OUT_TDATA_W = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// File: src/point_in_polygon_test.sv
// Point-in-polygon test by even-odd ray casting; uses pip_pkg and the assertion macros header.
// A query over n >= 3 vertices makes n + 1 table reads (last vertex first), one edge per cycle
// through the shared edge unit, then drains the edge pipeline and loads the output register;
// fewer than 3 vertices skip the walk and answer outside. A vertex write is taken in idle.
// A new query is taken only once the previous answer is loaded, which out_tready stalls can delay;
// writes transfer back to back. Reset (rst_n, sync, active low) spares the table and payload registers.
module point_in_polygon_test #(
  parameter int  MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
  parameter int  COORD_WIDTH  = pip_pkg::DEF_COORD_WIDTH,
  localparam int IN_TDATA_W   = ((pip_pkg::SLOT_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low to high: vertex_slot, coord_x, coord_y, zero fill
  input  logic [IN_TDATA_W-1:0]            in_tdata,
  // tuser: operation
  input  logic                             in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low to high: inside_res, zero fill
  output logic [pip_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration: vertex_count
  input  logic                             cfg_wr_en,
  input  logic [pip_pkg::COUNT_W-1:0]      cfg_wr_data
);
  import pip_pkg::*;

  `include "point_in_polygon_test_macros.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = COORD_WIDTH + 1;            // coordinate differences
  localparam int PW  = 2 * DW;                     // full products
  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW  = ($clog2(MAX_VERTICES + 1) > COUNT_W) ?
                       $clog2(MAX_VERTICES + 1) : COUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Unpack the input transfer.
  logic [SLOT_W-1:0]   in_slot;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic                in_acc;

  assign in_slot = in_tdata[SLOT_W-1:0];
  assign in_x    = in_tdata[SLOT_W +: CW];
  assign in_y    = in_tdata[SLOT_W + CW +: CW];

  // Control state.
  logic [1:0]    state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] issue_cnt_r, issue_cnt_nxt;
  logic          parity_r, parity_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          inside_r, inside_nxt;
  logic [COUNT_W-1:0] vertex_count_r, vertex_count_nxt;
  logic          rdv_r, rdfirst_r, ev_r;

  // Payload registers.
  logic signed [CW-1:0] px_r, py_r;
  logic signed [CW-1:0] rd_x_r, rd_y_r;
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic signed [PW-1:0] l_r, r_r;
  logic                 up_r, win_r;

  // Vertex table.
  logic [CW-1:0] mem_x [MAX_VERTICES];
  logic [CW-1:0] mem_y [MAX_VERTICES];

  logic          rd_en;
  logic [NW-1:0] last_idx, cnt_m1, n_q;
  logic [AW-1:0] rd_addr;
  logic          pipe_empty, done, hit, slot_ok;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Clamp the vertex count to the table depth.
  assign n_q = (NW'(vertex_count_r) < NW'(MAX_VERTICES)) ? NW'(vertex_count_r)
                                                         : NW'(MAX_VERTICES);

  // Read order: last vertex first (the wrap edge start), then 0 .. n-1.
  assign last_idx = n_r - NW'(1);
  assign cnt_m1   = issue_cnt_r - NW'(1);
  assign rd_en    = (state_r == ST_RUN);
  assign rd_addr  = (issue_cnt_r == '0) ? last_idx[AW-1:0] : cnt_m1[AW-1:0];

  assign pipe_empty = !rdv_r && !ev_r;
  assign done       = (state_r == ST_DRAIN) && pipe_empty && (!out_valid_r || out_tready);

  // Crossing test: ascending edges count when L <= R, descending when R <= L.
  assign hit = win_r && (up_r ? (l_r <= r_r) : (r_r <= l_r));

  assign slot_ok = (32'(in_slot) < MAX_VERTICES);

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    issue_cnt_nxt    = issue_cnt_r;
    parity_nxt       = parity_r;
    out_valid_nxt    = out_valid_r;
    inside_nxt       = inside_r;
    vertex_count_nxt = vertex_count_r;

    if (cfg_wr_en) begin
      vertex_count_nxt = cfg_wr_data;
    end

    // Toggle on every counted edge.
    if (ev_r && hit) begin
      parity_nxt = !parity_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_QUERY)) begin
          n_nxt         = n_q;
          issue_cnt_nxt = '0;
          parity_nxt    = 1'b0;
          // Fewer than three vertices: skip the walk and answer outside.
          state_nxt     = (n_q < NW'(3)) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        issue_cnt_nxt = issue_cnt_r + NW'(1);
        if (issue_cnt_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register: drop on transfer, load the final parity when done.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt = 1'b1;
      inside_nxt    = parity_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      n_r            <= '0;
      issue_cnt_r    <= '0;
      parity_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      inside_r       <= 1'b0;
      vertex_count_r <= '0;
      rdv_r          <= 1'b0;
      rdfirst_r      <= 1'b0;
      ev_r           <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      n_r            <= n_nxt;
      issue_cnt_r    <= issue_cnt_nxt;
      parity_r       <= parity_nxt;
      out_valid_r    <= out_valid_nxt;
      inside_r       <= inside_nxt;
      vertex_count_r <= vertex_count_nxt;
      rdv_r          <= rd_en;
      rdfirst_r      <= rd_en && (issue_cnt_r == '0);
      ev_r           <= rdv_r && !rdfirst_r;
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == OP_WRITE) && slot_ok) begin
      mem_x[AW'(in_slot)] <= in_x;
      mem_y[AW'(in_slot)] <= in_y;
    end
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  // Shared edge unit: edge from prev (a) to the vertex just read (b).
  logic signed [DW-1:0] d_px, d_bx, d_py, d_dy;
  logic signed [PW-1:0] l_nxt, r_nxt;
  logic                 win_nxt;

  assign d_px = {px_r[CW-1], px_r} - {prev_x_r[CW-1], prev_x_r};
  assign d_bx = {rd_x_r[CW-1], rd_x_r} - {prev_x_r[CW-1], prev_x_r};
  assign d_py = {py_r[CW-1], py_r} - {prev_y_r[CW-1], prev_y_r};
  assign d_dy = {rd_y_r[CW-1], rd_y_r} - {prev_y_r[CW-1], prev_y_r};

  assign l_nxt = d_px * d_dy;
  assign r_nxt = d_bx * d_py;

  // Query y in [min y, max y); empty for a horizontal edge.
  assign win_nxt = ((prev_y_r <= py_r) && (py_r < rd_y_r)) ||
                   ((rd_y_r <= py_r) && (py_r < prev_y_r));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (rdv_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    if (rdv_r && !rdfirst_r) begin
      l_r   <= l_nxt;
      r_r   <= r_nxt;
      up_r  <= (d_dy > 0);
      win_r <= win_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 1)'(0), inside_r};

  // Checks on the sequencer.
  `PIP_ASSERT_IMPLY(a_pipe_idle, rdv_r || ev_r, state_r != ST_IDLE, "edge pipeline busy in idle")
  `PIP_ASSERT_IMPLY(a_issue_bound, state_r == ST_RUN, issue_cnt_r <= n_r, "read past vertex count")
  `PIP_ASSERT_NEXT(a_out_from_drain, !out_valid_r && !done, !out_valid_r, "result without finish")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for point_in_polygon_test: vertex writes, vertex_count settings and
// point queries, each answer checked against an even-odd ray-casting predictor.
// Depends on pip_pkg and the point_in_polygon_test RTL.
module testbench;
  import pip_pkg::*;

  localparam int COORD_W    = DEF_COORD_WIDTH;
  localparam int TABLE_SIZE = DEF_MAX_VERTICES;
  localparam int IN_W       = ((SLOT_W + 2 * COORD_W + 7) / 8) * 8;
  // Longest query walks up to 16 vertices; leave margin.
  localparam int SETTLE      = 24;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_ITEMS  = 60;
  localparam int MAX_IDLE     = 12;

  localparam bit OUTSIDE = 1'b0;
  localparam bit INSIDE  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One row of the directed table: either a transfer or a vertex_count setting.
  typedef enum logic {ROW_XFER, ROW_COUNT} row_kind_t;
  typedef struct {
    row_kind_t kind;
    logic      op;
    slot_t     slot;
    coord_t    x;
    coord_t    y;
    count_t    count;
    bit        typed;
    bit        answer;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;   // low to high: vertex_slot, coord_x, coord_y, zero fill
  logic              in_tuser = 1'b0; // operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // low to high: inside_res, zero fill
  logic              cfg_wr_en = 1'b0;
  count_t            cfg_wr_data = '0;

  // Predictor state: its own copy of the vertex table and of vertex_count.
  coord_t    poly_x [TABLE_SIZE];
  coord_t    poly_y [TABLE_SIZE];
  count_t    poly_count = '0;

  bit        inside_expect [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        random_accepted = 0;
  int        tx_idle_max = MAX_IDLE;
  int        rx_idle_max = MAX_IDLE;

  point_in_polygon_test dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Even-odd ray casting over the vertices in use. The crossing test
  // px <= ax + (bx-ax)*(py-ay)/(by-ay) is done by cross-multiplying, with the
  // compare flipped for downward edges; products fit easily in 64 bits.
  function automatic bit ray_parity(input coord_t px, input coord_t py);
    int      n;
    int      prev;
    bit      odd;
    longint  qx, qy, ax, ay, bx, by, lo_y, hi_y, lhs, rhs;
    qx = px;
    qy = py;
    n = (poly_count > TABLE_SIZE) ? TABLE_SIZE : poly_count;
    odd = 1'b0;
    if (n >= 3) begin
      prev = n - 1;
      for (int i = 0; i < n; i++) begin
        ax = poly_x[prev];
        ay = poly_y[prev];
        bx = poly_x[i];
        by = poly_y[i];
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay < by) ? by : ay;
        // Horizontal edges drop out here: [y, y) is empty.
        if (qy >= lo_y && qy < hi_y) begin
          lhs = (qx - ax) * (by - ay);
          rhs = (bx - ax) * (qy - ay);
          if ((by > ay) ? (lhs <= rhs) : (rhs <= lhs)) odd = ~odd;
        end
        prev = i;
      end
    end
    return odd;
  endfunction

  function automatic coord_t coord_within(input int span);
    return coord_t'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  // Present one item after a random gap and hold it until the transfer.
  // Valid stays high on exit so that a back-to-back item needs no toggle.
  task automatic push_item(input logic op, input slot_t slot, input coord_t x,
                           input coord_t y, input bit typed, input bit typed_answer);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_W - SLOT_W - 2 * COORD_W){1'b0}}, y, x, slot};
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE) begin
      poly_x[slot] = x;
      poly_y[slot] = y;
    end else begin
      inside_expect = {inside_expect, (typed ? typed_answer : ray_parity(x, y))};
    end
  endtask

  // Drop valid, wait for every pending answer, then let a late write finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (inside_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_count(input count_t n);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    poly_count = n;
  endtask

  task automatic plan_item(input logic op, input slot_t slot, input coord_t x,
                           input coord_t y, input bit typed, input bit answer);
    plan_row_t r;
    r = '{kind: ROW_XFER, op: op, slot: slot, x: x, y: y, count: '0,
          typed: typed, answer: answer};
    plan = {plan, r};
  endtask

  task automatic plan_count(input count_t n);
    plan_row_t r;
    r = '{kind: ROW_COUNT, op: OP_WRITE, slot: '0, x: '0, y: '0, count: n,
          typed: 1'b0, answer: OUTSIDE};
    plan = {plan, r};
  endtask

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_idle_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Check every answer transfer against the oldest expectation.
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      if (inside_expect.size() == 0) begin
        $error("inside_res: no answer expected, got %0d", out_tdata[0]);
        mismatches++;
      end else begin
        want = inside_expect.pop_front();
        if (out_tdata[0] !== want) begin
          $error("inside_res: expected %0d, got %0d", want, out_tdata[0]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int     phase;
    int     n_cfg;
    int     n_used;
    int     span;
    int     pick;
    coord_t qx;
    coord_t qy;
    int     first_counts [6];

    first_counts = '{16, 31, 3, 0, 1, 2};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. After reset vertex_count is 0, so queries answer outside.
    plan_item(OP_QUERY, 4'd0,  16'sd0,      16'sd0,      1'b1, OUTSIDE);
    plan_item(OP_QUERY, 4'd15, -16'sd32768, -16'sd32768, 1'b1, OUTSIDE);
    plan_item(OP_QUERY, 4'd5,  16'sd32767,  16'sd32767,  1'b1, OUTSIDE);
    // Square of side 512 around the origin.
    plan_item(OP_WRITE, 4'd0, -16'sd256, -16'sd256, 1'b0, OUTSIDE);
    plan_item(OP_WRITE, 4'd1,  16'sd256, -16'sd256, 1'b0, OUTSIDE);
    plan_item(OP_WRITE, 4'd2,  16'sd256,  16'sd256, 1'b0, OUTSIDE);
    plan_item(OP_WRITE, 4'd3, -16'sd256,  16'sd256, 1'b0, OUTSIDE);
    // Fewer than three vertices: always outside.
    plan_count(5'd2);
    plan_item(OP_QUERY, 4'd0, 16'sd0, 16'sd0, 1'b1, OUTSIDE);
    plan_count(5'd4);
    plan_item(OP_QUERY, 4'd0,  16'sd0,    16'sd0,    1'b1, INSIDE);
    plan_item(OP_QUERY, 4'd0,  16'sd512,  16'sd0,    1'b1, OUTSIDE);
    // Boundary points: on the left side, on the bottom and top horizontal edges.
    plan_item(OP_QUERY, 4'd0, -16'sd256,  16'sd0,    1'b0, OUTSIDE);
    plan_item(OP_QUERY, 4'd0,  16'sd255, -16'sd256,  1'b0, OUTSIDE);
    plan_item(OP_QUERY, 4'd0,  16'sd0,    16'sd256,  1'b0, OUTSIDE);
    // Triangle spanning the whole coordinate range.
    plan_item(OP_WRITE, 4'd0, -16'sd32768, -16'sd32768, 1'b0, OUTSIDE);
    plan_item(OP_WRITE, 4'd1,  16'sd32767, -16'sd32768, 1'b0, OUTSIDE);
    plan_item(OP_WRITE, 4'd2,  16'sd0,      16'sd32767, 1'b0, OUTSIDE);
    plan_count(5'd3);
    plan_item(OP_QUERY, 4'd0,  16'sd0,      16'sd0,      1'b1, INSIDE);
    plan_item(OP_QUERY, 4'd0,  16'sd32767,  16'sd32767,  1'b1, OUTSIDE);
    plan_item(OP_QUERY, 4'd0, -16'sd32768, -16'sd32768,  1'b0, OUTSIDE);
    plan_item(OP_QUERY, 4'd0,  16'sd32767, -16'sd32768,  1'b0, OUTSIDE);
    plan_item(OP_QUERY, 4'd0, -16'sd32768,  16'sd0,      1'b0, OUTSIDE);
    plan_count(5'd0);
    plan_item(OP_QUERY, 4'd0, 16'sd0, 16'sd0, 1'b1, OUTSIDE);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_COUNT) begin
        load_count(plan[i].count);
      end else begin
        push_item(plan[i].op, plan[i].slot, plan[i].x, plan[i].y,
                  plan[i].typed, plan[i].answer);
      end
    end

    // Random part: each phase lays down a fresh polygon, sets vertex_count,
    // then mixes queries with vertex rewrites. Counts above the table depth
    // are clamped to the full table, so every slot in use is written first.
    phase = 0;
    while (random_accepted < RANDOM_ITEMS) begin
      if (phase < 6) n_cfg = first_counts[phase];
      else if ($urandom_range(0, 7) == 0) n_cfg = $urandom_range(17, 31);
      else n_cfg = $urandom_range(0, 16);
      n_used = (n_cfg > TABLE_SIZE) ? TABLE_SIZE : n_cfg;
      case ($urandom_range(0, 3))
        0:       span = 32768;
        1:       span = 4096;
        2:       span = 256;
        default: span = 8;
      endcase
      // Some phases run with no idling on one or both sides.
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;

      for (int s = 0; s < n_used; s++) begin
        push_item(OP_WRITE, slot_t'(s), coord_within(span), coord_within(span),
                  1'b0, OUTSIDE);
        random_accepted++;
      end
      load_count(count_t'(n_cfg));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // Rewrite any slot; slots in use move the polygon under the queries.
          push_item(OP_WRITE, slot_t'($urandom_range(0, TABLE_SIZE - 1)),
                    coord_within(span), coord_within(span), 1'b0, OUTSIDE);
        end else begin
          if (pick < 5 && n_used > 0) begin
            // Hit a vertex's y exactly to exercise the half-open range.
            qy = poly_y[$urandom_range(0, n_used - 1)];
            qx = coord_within(span);
          end else if (pick < 9) begin
            qx = coord_within(span);
            qy = coord_within(span);
          end else begin
            qx = coord_within(32768);
            qy = coord_within(32768);
          end
          push_item(OP_QUERY, slot_t'($urandom_range(0, TABLE_SIZE - 1)), qx, qy,
                    1'b0, OUTSIDE);
        end
        random_accepted++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && inside_expect.size() == 0) begin
      $display("[point_in_polygon_test] OK");
    end else begin
      $display("[point_in_polygon_test] ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("[point_in_polygon_test] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/pip_pkg.sv
src/point_in_polygon_test.sv
bench/testbench.sv
